/* rtl/hsc_pkg.sv */
// Shared constants, codes and types of the heightmap slope classifier.
package hsc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_MAX_DEPTH   = 4096;
  localparam int DEF_HEIGHT_BITS = 16;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_DEPTH       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLAT_THRESHOLD  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUILD_THRESHOLD = 2'd3;

  // Reset values of the configuration registers.
  localparam int RST_MAP_WIDTH       = 64;
  localparam int RST_MAP_DEPTH       = 64;
  localparam int RST_FLAT_THRESHOLD  = 1;
  localparam int RST_BUILD_THRESHOLD = 2;

  // Cell class codes.
  localparam logic [1:0] CLASS_WATER    = 2'd0;
  localparam logic [1:0] CLASS_FLAT     = 2'd1;
  localparam logic [1:0] CLASS_SLOPE_OK = 2'd2;
  localparam logic [1:0] CLASS_STEEP    = 2'd3;

  // Kinds of result one request can cause, in emission order.
  localparam logic [1:0] KIND_ABOVE = 2'd0;
  localparam logic [1:0] KIND_LEFT  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Position flags worked out by the front part for each request.
  typedef struct packed {
    logic has_above;  // a row above exists
    logic has_up;     // the cell above has a row above it
    logic has_left;   // column is at least one
    logic has_left2;  // column is at least two
    logic has_right;  // a column to the right exists
    logic last_row;   // request lies in the last row of the map
    logic row_end;    // request is the last cell of its row
    logic multi_row;  // the map has two or more rows
  } hsc_flags_t;

endpackage

/* rtl/hsc_fifo.sv */
// Small request queue between the front and back parts.
module hsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/hsc_front.sv */
// Front part: raster counters, the two line memories and the read stage.
module hsc_front #(
  parameter int MAX_WIDTH   = hsc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_DEPTH   = hsc_pkg::DEF_MAX_DEPTH,
  parameter int HEIGHT_BITS = hsc_pkg::DEF_HEIGHT_BITS,
  parameter int Q_DEPTH     = hsc_pkg::QUEUE_DEPTH,
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  localparam int WCFG_W = $clog2(MAX_WIDTH + 1),
  localparam int DCFG_W = $clog2(MAX_DEPTH + 1),
  localparam int QCNT_W = $clog2(Q_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [WCFG_W-1:0]             map_width,
  input  logic [DCFG_W-1:0]             map_depth,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [HEIGHT_BITS-1:0] height_sample,
  input  logic                          water_flag,
  input  logic [QCNT_W-1:0]             q_count,
  output logic                          item_valid,
  output hsc_pkg::hsc_flags_t           item_flags,
  output logic [COL_W-1:0]              item_col,
  output logic [ROW_W-1:0]              item_row,
  output logic signed [HEIGHT_BITS-1:0] item_height,
  output logic                          item_water,
  output logic signed [HEIGHT_BITS-1:0] mid_height,
  output logic                          mid_water,
  output logic signed [HEIGHT_BITS-1:0] right_height,
  output logic signed [HEIGHT_BITS-1:0] up_height
);

  // Line memories hold {water, height}; their roles swap at each row end but the map's last, where select returns low.
  logic [HEIGHT_BITS:0] mem_a [MAX_WIDTH];
  logic [HEIGHT_BITS:0] mem_b [MAX_WIDTH];
  logic [HEIGHT_BITS:0] a_rd0;
  logic [HEIGHT_BITS:0] a_rd1;
  logic [HEIGHT_BITS:0] b_rd0;
  logic [HEIGHT_BITS:0] b_rd1;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              sel;
  logic [COL_W-1:0]  col_nx;
  logic [WCFG_W-1:0] w_eff;
  logic [DCFG_W-1:0] d_eff;
  logic              col_last;
  logic              row_last;
  logic              accept;
  hsc_pkg::hsc_flags_t flags;

  logic                          s1_valid;
  hsc_pkg::hsc_flags_t           s1_flags;
  logic [COL_W-1:0]              s1_col;
  logic [ROW_W-1:0]              s1_row;
  logic signed [HEIGHT_BITS-1:0] s1_h;
  logic                          s1_w;
  logic                          s1_sel;

  // Effective map size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (map_width == '0) begin
      w_eff = WCFG_W'(1);
    end else if (map_width > WCFG_W'(MAX_WIDTH)) begin
      w_eff = WCFG_W'(MAX_WIDTH);
    end else begin
      w_eff = map_width;
    end
    if (map_depth == '0) begin
      d_eff = DCFG_W'(1);
    end else if (map_depth > DCFG_W'(MAX_DEPTH)) begin
      d_eff = DCFG_W'(MAX_DEPTH);
    end else begin
      d_eff = map_depth;
    end
  end

  // Position of the incoming request.
  assign col_nx   = col + COL_W'(1);
  assign col_last = (WCFG_W'(col) + WCFG_W'(1)) >= w_eff;
  assign row_last = (DCFG_W'(row) + DCFG_W'(1)) >= d_eff;

  always_comb begin
    flags.has_above = (row != '0);
    flags.has_up    = (row > ROW_W'(1));
    flags.has_left  = (col != '0);
    flags.has_left2 = (col > COL_W'(1));
    flags.has_right = !col_last;
    flags.last_row  = row_last;
    flags.row_end   = col_last;
    flags.multi_row = (d_eff > DCFG_W'(1));
  end

  // The read stage always drains into the queue, so hold off only when it could overflow.
  assign sample_stall = (q_count == QCNT_W'(Q_DEPTH)) ||
                        (s1_valid && (q_count == QCNT_W'(Q_DEPTH - 1)));
  assign accept = sample_valid && !sample_stall;

  // Raster counters and line select.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
      sel <= 1'b0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row <= '0;
          sel <= 1'b0;
        end else begin
          row <= row + ROW_W'(1);
          sel <= !sel;
        end
      end else begin
        col <= col_nx;
      end
    end
  end

  // Line memories: read the column and its right neighbor, write the new sample.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_rd0 <= mem_a[col];
      a_rd1 <= mem_a[col_nx];
      b_rd0 <= mem_b[col];
      b_rd1 <= mem_b[col_nx];
      if (!sel) begin
        mem_a[col] <= {water_flag, height_sample};
      end else begin
        mem_b[col] <= {water_flag, height_sample};
      end
    end
  end

  // Read stage register alongside the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= flags;
      s1_col   <= col;
      s1_row   <= row;
      s1_h     <= height_sample;
      s1_w     <= water_flag;
      s1_sel   <= sel;
    end
  end

  // With select low the previous row sits in memory B, the row before it in A.
  assign item_valid   = s1_valid;
  assign item_flags   = s1_flags;
  assign item_col     = s1_col;
  assign item_row     = s1_row;
  assign item_height  = s1_h;
  assign item_water   = s1_w;
  assign mid_height   = s1_sel ? a_rd0[HEIGHT_BITS-1:0] : b_rd0[HEIGHT_BITS-1:0];
  assign mid_water    = s1_sel ? a_rd0[HEIGHT_BITS] : b_rd0[HEIGHT_BITS];
  assign right_height = s1_sel ? a_rd1[HEIGHT_BITS-1:0] : b_rd1[HEIGHT_BITS-1:0];
  assign up_height    = s1_sel ? b_rd0[HEIGHT_BITS-1:0] : a_rd0[HEIGHT_BITS-1:0];

endmodule

/* rtl/hsc_back.sv */
// Back part: slope, class, running count and the result register.
module hsc_back #(
  parameter int MAX_WIDTH   = hsc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_DEPTH   = hsc_pkg::DEF_MAX_DEPTH,
  parameter int HEIGHT_BITS = hsc_pkg::DEF_HEIGHT_BITS,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [HEIGHT_BITS-1:0]        flat_threshold,
  input  logic [HEIGHT_BITS-1:0]        buildable_threshold,
  input  logic                          item_valid,
  output logic                          item_pop,
  input  hsc_pkg::hsc_flags_t           item_flags,
  input  logic [COL_W-1:0]              item_col,
  input  logic [ROW_W-1:0]              item_row,
  input  logic signed [HEIGHT_BITS-1:0] item_height,
  input  logic                          item_water,
  input  logic signed [HEIGHT_BITS-1:0] mid_height,
  input  logic                          mid_water,
  input  logic signed [HEIGHT_BITS-1:0] right_height,
  input  logic signed [HEIGHT_BITS-1:0] up_height,
  output logic                          cell_valid,
  input  logic                          cell_stall,
  output logic [COL_W-1:0]              cell_col,
  output logic [ROW_W-1:0]              cell_row,
  output logic signed [HEIGHT_BITS-1:0] cell_height,
  output logic [HEIGHT_BITS-1:0]        cell_slope,
  output logic                          cell_water,
  output logic [1:0]                    cell_class,
  output logic [CNT_W-1:0]              buildable_count,
  output logic                          last_cell
);

  // Absolute difference of two heights; it always fits the unsigned height width.
  function automatic logic [HEIGHT_BITS-1:0] abs_diff(
    input logic signed [HEIGHT_BITS-1:0] a,
    input logic signed [HEIGHT_BITS-1:0] b
  );
    logic signed [HEIGHT_BITS:0] d;
    logic        [HEIGHT_BITS:0] m;
    d = {a[HEIGHT_BITS-1], a} - {b[HEIGHT_BITS-1], b};
    m = d[HEIGHT_BITS] ? -d : d;
    return m[HEIGHT_BITS-1:0];
  endfunction

  // History of the current row and the previous row's window.
  logic signed [HEIGHT_BITS-1:0] prev_mid;
  logic signed [HEIGHT_BITS-1:0] h1;
  logic signed [HEIGHT_BITS-1:0] h2;
  logic                          w1;

  logic [1:0]       phase;
  logic [CNT_W-1:0] ok_count;

  logic [2:0] present;
  logic [2:0] mask;
  logic [2:0] remaining;
  logic [1:0] kind;
  logic       more;
  logic       out_free;
  logic       emit;

  logic signed [HEIGHT_BITS-1:0] c;
  logic signed [HEIGHT_BITS-1:0] n0;
  logic signed [HEIGHT_BITS-1:0] n1;
  logic signed [HEIGHT_BITS-1:0] n2;
  logic                          en0;
  logic                          en1;
  logic                          en2;
  logic                          en3;
  logic [COL_W-1:0]              sel_col;
  logic [ROW_W-1:0]              sel_row;
  logic                          sel_water;
  logic                          sel_last;

  logic [HEIGHT_BITS-1:0] d0;
  logic [HEIGHT_BITS-1:0] d1;
  logic [HEIGHT_BITS-1:0] d2;
  logic [HEIGHT_BITS-1:0] d3;
  logic [HEIGHT_BITS-1:0] m01;
  logic [HEIGHT_BITS-1:0] m23;
  logic [HEIGHT_BITS-1:0] slope;
  logic [1:0]             cls;
  logic [CNT_W-1:0]       count_next;

  // Which results this request still owes.
  assign present = {item_flags.last_row && item_flags.row_end,
                    item_flags.last_row && item_flags.has_left,
                    item_flags.has_above};

  always_comb begin
    case (phase)
      hsc_pkg::KIND_ABOVE: mask = 3'b111;
      hsc_pkg::KIND_LEFT:  mask = 3'b110;
      hsc_pkg::KIND_END:   mask = 3'b100;
      default:             mask = 3'b111;
    endcase
    remaining = present & mask;
    if (remaining[0]) begin
      kind = hsc_pkg::KIND_ABOVE;
      more = (remaining[2:1] != 2'b00);
    end else if (remaining[1]) begin
      kind = hsc_pkg::KIND_LEFT;
      more = remaining[2];
    end else begin
      kind = hsc_pkg::KIND_END;
      more = 1'b0;
    end
  end

  assign out_free = !cell_valid || !cell_stall;
  assign emit     = item_valid && (remaining != 3'b000) && out_free;
  assign item_pop = item_valid && ((remaining == 3'b000) || (emit && !more));

  // Center cell and its in-bounds neighbors for the result being formed.
  always_comb begin
    c         = item_height;
    n0        = prev_mid;
    n1        = item_height;
    n2        = up_height;
    en0       = 1'b0;
    en1       = 1'b0;
    en2       = 1'b0;
    en3       = 1'b0;
    sel_col   = item_col;
    sel_row   = item_row;
    sel_water = item_water;
    sel_last  = 1'b0;
    case (kind)
      hsc_pkg::KIND_ABOVE: begin
        c         = mid_height;
        n0        = prev_mid;
        en0       = item_flags.has_left;
        n1        = right_height;
        en1       = item_flags.has_right;
        n2        = up_height;
        en2       = item_flags.has_up;
        en3       = 1'b1;
        sel_row   = item_row - ROW_W'(1);
        sel_water = mid_water;
      end
      hsc_pkg::KIND_LEFT: begin
        c         = h1;
        n0        = h2;
        en0       = item_flags.has_left2;
        n1        = item_height;
        en1       = 1'b1;
        n2        = prev_mid;
        en2       = item_flags.multi_row;
        sel_col   = item_col - COL_W'(1);
        sel_water = w1;
      end
      hsc_pkg::KIND_END: begin
        c         = item_height;
        n0        = h1;
        en0       = item_flags.has_left;
        n2        = mid_height;
        en2       = item_flags.multi_row;
        sel_last  = 1'b1;
      end
      default: begin
        sel_last = 1'b0;
      end
    endcase
  end

  // Slope is the largest enabled difference; the fourth slot is always the new sample.
  assign d0  = en0 ? abs_diff(c, n0) : '0;
  assign d1  = en1 ? abs_diff(c, n1) : '0;
  assign d2  = en2 ? abs_diff(c, n2) : '0;
  assign d3  = en3 ? abs_diff(c, item_height) : '0;
  assign m01 = (d0 > d1) ? d0 : d1;
  assign m23 = (d2 > d3) ? d2 : d3;
  assign slope = (m01 > m23) ? m01 : m23;

  // Class, with the flat test first even when the thresholds cross.
  always_comb begin
    if (sel_water) begin
      cls = hsc_pkg::CLASS_WATER;
    end else if (slope <= flat_threshold) begin
      cls = hsc_pkg::CLASS_FLAT;
    end else if (slope <= buildable_threshold) begin
      cls = hsc_pkg::CLASS_SLOPE_OK;
    end else begin
      cls = hsc_pkg::CLASS_STEEP;
    end
    if (((cls == hsc_pkg::CLASS_FLAT) || (cls == hsc_pkg::CLASS_SLOPE_OK)) && !(&ok_count)) begin
      count_next = ok_count + CNT_W'(1);
    end else begin
      count_next = ok_count;
    end
  end

  // Result sequencing and running count; the count restarts after the last cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= hsc_pkg::KIND_ABOVE;
      ok_count <= '0;
    end else begin
      if (item_pop) begin
        phase <= hsc_pkg::KIND_ABOVE;
      end else if (emit) begin
        phase <= (kind == hsc_pkg::KIND_ABOVE) ? hsc_pkg::KIND_LEFT : hsc_pkg::KIND_END;
      end
      if (restart) begin
        ok_count <= '0;
      end else if (emit) begin
        ok_count <= sel_last ? '0 : count_next;
      end
    end
  end

  // Row history, advanced once a request is finished.
  always_ff @(posedge clk) begin
    if (item_pop) begin
      prev_mid <= mid_height;
      h1       <= item_height;
      h2       <= h1;
      w1       <= item_water;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (emit) begin
      cell_valid <= 1'b1;
    end else if (!cell_stall) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cell_col        <= sel_col;
      cell_row        <= sel_row;
      cell_height     <= c;
      cell_slope      <= slope;
      cell_water      <= sel_water;
      cell_class      <= cls;
      buildable_count <= count_next;
      last_cell       <= sel_last;
    end
  end

endmodule

/* rtl/heightmap_slope_classifier_top.sv */
// Top level of the heightmap slope classifier: configuration registers and wiring.
//
//   Channel   Handshake              Payload
//   sample    sample_valid / stall   height_sample, water_flag
//   cell      cell_valid / stall     cell_col .. last_cell (up to three per request)
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample is taken per cycle while sample_stall is low. On the last row a sample
// owes up to three results, and the back part sends one result per cycle unless
// cell_stall holds it, so the four-entry queue fills there and sample_stall rises.
// cell_stall holds the result register. Reset clears the counters and handshake
// state at once; the line memories are not cleared.
module heightmap_slope_classifier_top #(
  parameter int MAX_WIDTH   = hsc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_DEPTH   = hsc_pkg::DEF_MAX_DEPTH,
  parameter int HEIGHT_BITS = hsc_pkg::DEF_HEIGHT_BITS,
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_DEPTH + 1),
  localparam int WCFG_W = $clog2(MAX_WIDTH + 1),
  localparam int DCFG_W = $clog2(MAX_DEPTH + 1),
  localparam int SIZE_W = (WCFG_W > DCFG_W) ? WCFG_W : DCFG_W,
  localparam int CFG_W  = (SIZE_W > HEIGHT_BITS) ? SIZE_W : HEIGHT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                 cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic signed [HEIGHT_BITS-1:0]    height_sample,
  input  logic                             water_flag,
  output logic                             cell_valid,
  input  logic                             cell_stall,
  output logic [COL_W-1:0]                 cell_col,
  output logic [ROW_W-1:0]                 cell_row,
  output logic signed [HEIGHT_BITS-1:0]    cell_height,
  output logic [HEIGHT_BITS-1:0]           cell_slope,
  output logic                             cell_water,
  output logic [1:0]                       cell_class,
  output logic [CNT_W-1:0]                 buildable_count,
  output logic                             last_cell
);

  localparam int FLAGS_W = $bits(hsc_pkg::hsc_flags_t);
  localparam int ITEM_W  = FLAGS_W + COL_W + ROW_W + 4 * HEIGHT_BITS + 2;
  localparam int QCNT_W  = $clog2(hsc_pkg::QUEUE_DEPTH + 1);

  logic [WCFG_W-1:0]      map_width;
  logic [DCFG_W-1:0]      map_depth;
  logic [HEIGHT_BITS-1:0] flat_threshold;
  logic [HEIGHT_BITS-1:0] buildable_threshold;
  logic                   cfg_write;
  logic                   restart;

  logic                          f_valid;
  hsc_pkg::hsc_flags_t           f_flags;
  logic [COL_W-1:0]              f_col;
  logic [ROW_W-1:0]              f_row;
  logic signed [HEIGHT_BITS-1:0] f_height;
  logic                          f_water;
  logic signed [HEIGHT_BITS-1:0] f_mid_height;
  logic                          f_mid_water;
  logic signed [HEIGHT_BITS-1:0] f_right_height;
  logic signed [HEIGHT_BITS-1:0] f_up_height;

  logic [ITEM_W-1:0] push_data;
  logic [ITEM_W-1:0] head_data;
  logic              head_valid;
  logic              pop;
  logic [QCNT_W-1:0] q_count;

  hsc_pkg::hsc_flags_t           b_flags;
  logic [COL_W-1:0]              b_col;
  logic [ROW_W-1:0]              b_row;
  logic signed [HEIGHT_BITS-1:0] b_height;
  logic                          b_water;
  logic signed [HEIGHT_BITS-1:0] b_mid_height;
  logic                          b_mid_water;
  logic signed [HEIGHT_BITS-1:0] b_right_height;
  logic signed [HEIGHT_BITS-1:0] b_up_height;

  // Configuration writes are always taken; size writes restart the map.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write &&
                     ((cfg_index == hsc_pkg::CFG_MAP_WIDTH) ||
                      (cfg_index == hsc_pkg::CFG_MAP_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width           <= WCFG_W'(hsc_pkg::RST_MAP_WIDTH);
      map_depth           <= DCFG_W'(hsc_pkg::RST_MAP_DEPTH);
      flat_threshold      <= HEIGHT_BITS'(hsc_pkg::RST_FLAT_THRESHOLD);
      buildable_threshold <= HEIGHT_BITS'(hsc_pkg::RST_BUILD_THRESHOLD);
    end else if (cfg_write) begin
      case (cfg_index)
        hsc_pkg::CFG_MAP_WIDTH:       map_width           <= cfg_data[WCFG_W-1:0];
        hsc_pkg::CFG_MAP_DEPTH:       map_depth           <= cfg_data[DCFG_W-1:0];
        hsc_pkg::CFG_FLAT_THRESHOLD:  flat_threshold      <= cfg_data[HEIGHT_BITS-1:0];
        hsc_pkg::CFG_BUILD_THRESHOLD: buildable_threshold <= cfg_data[HEIGHT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front part.
  hsc_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_DEPTH   (MAX_DEPTH),
    .HEIGHT_BITS (HEIGHT_BITS),
    .Q_DEPTH     (hsc_pkg::QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .map_width     (map_width),
    .map_depth     (map_depth),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .height_sample (height_sample),
    .water_flag    (water_flag),
    .q_count       (q_count),
    .item_valid    (f_valid),
    .item_flags    (f_flags),
    .item_col      (f_col),
    .item_row      (f_row),
    .item_height   (f_height),
    .item_water    (f_water),
    .mid_height    (f_mid_height),
    .mid_water     (f_mid_water),
    .right_height  (f_right_height),
    .up_height     (f_up_height)
  );

  // Queue between the parts.
  assign push_data = {f_flags, f_col, f_row, f_height, f_water,
                      f_mid_height, f_mid_water, f_right_height, f_up_height};

  hsc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (hsc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  assign {b_flags, b_col, b_row, b_height, b_water,
          b_mid_height, b_mid_water, b_right_height, b_up_height} = head_data;

  // Back part.
  hsc_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_DEPTH   (MAX_DEPTH),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .restart             (restart),
    .flat_threshold      (flat_threshold),
    .buildable_threshold (buildable_threshold),
    .item_valid          (head_valid),
    .item_pop            (pop),
    .item_flags          (b_flags),
    .item_col            (b_col),
    .item_row            (b_row),
    .item_height         (b_height),
    .item_water          (b_water),
    .mid_height          (b_mid_height),
    .mid_water           (b_mid_water),
    .right_height        (b_right_height),
    .up_height           (b_up_height),
    .cell_valid          (cell_valid),
    .cell_stall          (cell_stall),
    .cell_col            (cell_col),
    .cell_row            (cell_row),
    .cell_height         (cell_height),
    .cell_slope          (cell_slope),
    .cell_water          (cell_water),
    .cell_class          (cell_class),
    .buildable_count     (buildable_count),
    .last_cell           (last_cell)
  );

endmodule

/* test/heightmap_slope_classifier_top_test.sv */
// Self-checking testbench for the heightmap slope classifier top level.
module heightmap_slope_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS = 200;
  localparam int DEEP_SAMPLES = 48;

  typedef struct {
    logic [5:0]         col;
    logic [11:0]        row;
    logic signed [15:0] height;
    logic [15:0]        slope;
    logic               water;
    logic [1:0]         cls;
    logic [18:0]        count;
    logic               last;
  } cell_result_t;

  // Block ports.
  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [hsc_pkg::CFG_INDEX_W-1:0] cfg_index = hsc_pkg::CFG_MAP_WIDTH;
  logic [15:0]                     cfg_data = '0;
  logic                            sample_valid = 1'b0;
  logic                            sample_stall;
  logic signed [15:0]              height_sample = '0;
  logic                            water_flag = 1'b0;
  logic                            cell_valid;
  logic                            cell_stall = 1'b0;
  logic [5:0]                      cell_col;
  logic [11:0]                     cell_row;
  logic signed [15:0]              cell_height;
  logic [15:0]                     cell_slope;
  logic                            cell_water;
  logic [1:0]                      cell_class;
  logic [18:0]                     buildable_count;
  logic                            last_cell;

  // Shadow copy of the configuration and the classifier state.
  logic [6:0]         map_width_reg;
  logic [12:0]        map_depth_reg;
  logic [15:0]        flat_limit;
  logic [15:0]        build_limit;
  logic signed [15:0] height_line [2][64];
  logic               water_line [2][64];
  int                 col_pos;
  int                 row_pos;
  logic               line_sel;
  logic [18:0]        build_total;

  cell_result_t cell_queue [$];
  int  mismatch_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  quiet_mode = 1'b0;

  heightmap_slope_classifier_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .height_sample(height_sample),
    .water_flag(water_flag),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .cell_col(cell_col),
    .cell_row(cell_row),
    .cell_height(cell_height),
    .cell_slope(cell_slope),
    .cell_water(cell_water),
    .cell_class(cell_class),
    .buildable_count(buildable_count),
    .last_cell(last_cell)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sizes as the block uses them: zero acts as one, oversize as the maximum.
  function automatic int eff_width();
    if (map_width_reg == 0) return 1;
    return (map_width_reg > hsc_pkg::DEF_MAX_WIDTH) ?
           hsc_pkg::DEF_MAX_WIDTH : int'(map_width_reg);
  endfunction

  function automatic int eff_depth();
    if (map_depth_reg == 0) return 1;
    return (map_depth_reg > hsc_pkg::DEF_MAX_DEPTH) ?
           hsc_pkg::DEF_MAX_DEPTH : int'(map_depth_reg);
  endfunction

  function automatic int wider(int slope, int center, int neighbor);
    int diff;
    diff = (center >= neighbor) ? center - neighbor : neighbor - center;
    return (diff > slope) ? diff : slope;
  endfunction

  function automatic void restart_map();
    col_pos = 0;
    row_pos = 0;
    line_sel = 1'b0;
    build_total = '0;
  endfunction

  // Classify one finished cell and queue it as an expected result.
  function automatic void push_cell(int col, int row, int height, int slope, logic water,
                                    logic last);
    cell_result_t r;
    if (water) r.cls = hsc_pkg::CLASS_WATER;
    else if (slope <= int'(flat_limit)) r.cls = hsc_pkg::CLASS_FLAT;
    else if (slope <= int'(build_limit)) r.cls = hsc_pkg::CLASS_SLOPE_OK;
    else r.cls = hsc_pkg::CLASS_STEEP;
    if ((r.cls == hsc_pkg::CLASS_FLAT || r.cls == hsc_pkg::CLASS_SLOPE_OK) &&
        build_total != '1)
      build_total++;
    r.col = 6'(col);
    r.row = 12'(row);
    r.height = 16'(height);
    r.slope = 16'(slope);
    r.water = water;
    r.count = build_total;
    r.last = last;
    cell_queue.push_back(r);
  endfunction

  // Work out every cell that one accepted sample finishes.
  task automatic predict_sample(input logic signed [15:0] h_in, input logic w_in);
    int   wmax, dmax, x, z, c, s, h;
    logic fresh, prior;
    wmax = eff_width();
    dmax = eff_depth();
    x = col_pos;
    z = row_pos;
    if (x >= wmax) x = wmax - 1;
    if (z >= dmax) z = dmax - 1;
    h = h_in;
    fresh = line_sel;
    prior = !line_sel;
    // The cell above the sample now has its lower neighbor.
    if (z >= 1) begin
      c = height_line[prior][x];
      s = 0;
      if (x > 0) s = wider(s, c, height_line[prior][x-1]);
      if (x + 1 < wmax) s = wider(s, c, height_line[prior][x+1]);
      if (z >= 2) s = wider(s, c, height_line[fresh][x]);
      s = wider(s, c, h);
      push_cell(x, z - 1, c, s, water_line[prior][x], 1'b0);
    end
    height_line[fresh][x] = h_in;
    water_line[fresh][x] = w_in;
    // On the last row the left cell is finished, and at the row end the sample too.
    if (z == dmax - 1) begin
      if (x >= 1) begin
        c = height_line[fresh][x-1];
        s = 0;
        if (x >= 2) s = wider(s, c, height_line[fresh][x-2]);
        s = wider(s, c, h);
        if (dmax >= 2) s = wider(s, c, height_line[prior][x-1]);
        push_cell(x - 1, z, c, s, water_line[fresh][x-1], 1'b0);
      end
      if (x == wmax - 1) begin
        s = 0;
        if (x >= 1) s = wider(s, h, height_line[fresh][x-1]);
        if (dmax >= 2) s = wider(s, h, height_line[prior][x]);
        push_cell(x, z, h, s, w_in, 1'b1);
      end
    end
    // Advance the raster position.
    if (x + 1 >= wmax) begin
      if (z + 1 >= dmax) begin
        restart_map();
      end else begin
        col_pos = 0;
        row_pos = z + 1;
        line_sel = !line_sel;
      end
    end else begin
      col_pos = x + 1;
    end
  endtask

  // Send one sample request after a random gap, none in quiet mode, and predict its results.
  task automatic send_sample(input logic signed [15:0] h, input logic w);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    height_sample <= h;
    water_flag <= w;
    do @(posedge clk); while (sample_stall);
    predict_sample(h, w);
    items_sent++;
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (cell_queue.size() != 0);
  endtask

  // Write one register; the caller lowers cfg_valid after the last write.
  task automatic write_reg(input logic [hsc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hsc_pkg::CFG_MAP_WIDTH: begin
        map_width_reg = value[6:0];
        restart_map();
      end
      hsc_pkg::CFG_MAP_DEPTH: begin
        map_depth_reg = value[12:0];
        restart_map();
      end
      hsc_pkg::CFG_FLAT_THRESHOLD: flat_limit = value;
      hsc_pkg::CFG_BUILD_THRESHOLD: build_limit = value;
      default: ;
    endcase
  endtask

  // Reconfigure once the block has drained.
  task automatic set_map(int w, int d, int flat_t, int build_t);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(hsc_pkg::CFG_MAP_WIDTH, 16'(w));
    write_reg(hsc_pkg::CFG_MAP_DEPTH, 16'(d));
    write_reg(hsc_pkg::CFG_FLAT_THRESHOLD, 16'(flat_t));
    write_reg(hsc_pkg::CFG_BUILD_THRESHOLD, 16'(build_t));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_height(int base, int spread);
    int v;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    return 16'(v);
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 3);
      2: return $urandom_range(2, 8);
      3: return $urandom_range(0, 50);
      4: return $urandom_range(0, 65535);
      default: return 65535;
    endcase
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 3;
      4: return 6;
      5: return 50;
      default: return 20000;
    endcase
  endfunction

  // Reset settings, a little over one row so the first cells come out.
  task automatic test_reset_settings();
    for (int i = 0; i < 66; i++)
      send_sample(pick_height(100, 2), $urandom_range(0, 7) == 0);
  endtask

  // Height extremes, full-scale slopes, water, and the water, slope-ok and steep classes.
  task automatic test_field_extremes();
    logic signed [15:0] heights [9];
    logic               waters [9];
    heights = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd32768,
                16'sd32767, 16'sd32767, 16'sd32766};
    waters = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    set_map(3, 3, 1, 40000);
    for (int i = 0; i < 9; i++) send_sample(heights[i], waters[i]);
  endtask

  // One-cell maps back to back: each sample is a whole map.
  task automatic test_single_cells();
    set_map(1, 1, 0, 0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b1);
    send_sample(16'sd0, 1'b0);
  endtask

  // A single row is the last row from its first sample.
  task automatic test_single_row();
    set_map(4, 1, 2, 3);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd1, 1'b1);
  endtask

  task automatic test_single_column();
    set_map(1, 3, 0, 1);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd11, 1'b0);
    send_sample(16'sd11, 1'b0);
  endtask

  // Flat threshold above the buildable one: the flat test still wins.
  task automatic test_crossed_thresholds();
    set_map(2, 2, 5, 2);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd10, 1'b0);
  endtask

  // Zero sizes act as one.
  task automatic test_zero_sizes();
    set_map(0, 0, 0, 0);
    send_sample(16'sd7, 1'b0);
    send_sample(-16'sd7, 1'b0);
  endtask

  // Random maps of mostly small sizes, some cut short, some repeated.
  task automatic test_random_maps();
    int target, w, d, cells, count, hold_at, spread, base, map_index;
    target = items_sent + RANDOM_ITEMS;
    map_index = 0;
    while (items_sent < target) begin
      quiet_mode = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: w = $urandom_range(1, 6);
        7, 8: w = $urandom_range(7, 16);
        default: w = $urandom_range(17, 64);
      endcase
      d = (w > 16) ? $urandom_range(1, 3) :
          ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      set_map(w, d, pick_threshold(), pick_threshold());
      cells = w * d;
      count = cells;
      if (cells > 1 && $urandom_range(0, 6) == 0) count = $urandom_range(1, cells - 1);
      else if ($urandom_range(0, 4) == 0) count = 2 * cells;
      hold_at = (map_index == 0 || $urandom_range(0, 3) == 0) ?
                int'($urandom_range(0, count - 1)) : -1;
      spread = pick_spread();
      base = int'($signed(16'($urandom)));
      for (int i = 0; i < count; i++) begin
        if (i == hold_at) wait_results();
        send_sample(pick_height(base, spread), $urandom_range(0, 5) == 0);
      end
      map_index++;
    end
    quiet_mode = 1'b0;
  endtask

  // Oversize width: 200 keeps 72 in seven bits, which acts as 64.
  task automatic test_widest_map();
    int base;
    base = int'($signed(16'($urandom)));
    set_map(200, 2, 2, 6);
    for (int i = 0; i < 128; i++)
      send_sample(pick_height(base, 3), $urandom_range(0, 5) == 0);
  endtask

  // Oversize depth acts as the full 4096 rows; the opening rows of one column
  // show that the map does not end early.
  task automatic test_deepest_map();
    quiet_mode = 1'b1;
    set_map(1, 8191, 1, 3);
    for (int i = 0; i < DEEP_SAMPLES; i++)
      send_sample(pick_height(-200, 2), $urandom_range(0, 9) == 0);
    quiet_mode = 1'b0;
  endtask

  // Result side stall: a random hold after every accepted result, none in quiet mode.
  always @(posedge clk) begin
    if (rst) begin
      cell_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (cell_valid && !cell_stall) stall_left = quiet_mode ? 0 : $urandom_range(0, 16);
      if (stall_left > 0) begin
        cell_stall <= 1'b1;
        stall_left--;
      end else begin
        cell_stall <= 1'b0;
      end
    end
  end

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk) begin : cell_check
    cell_result_t want;
    if (!rst && cell_valid && !cell_stall) begin
      if (cell_queue.size() == 0) begin
        $error("result with no expected cell: col %0d row %0d", cell_col, cell_row);
        mismatch_count++;
      end else begin
        want = cell_queue.pop_front();
        compare_field("cell_col", want.col, cell_col);
        compare_field("cell_row", want.row, cell_row);
        compare_field("cell_height", want.height, cell_height);
        compare_field("cell_slope", want.slope, cell_slope);
        compare_field("cell_water", want.water, cell_water);
        compare_field("cell_class", want.cls, cell_class);
        compare_field("buildable_count", want.count, buildable_count);
        compare_field("last_cell", want.last, last_cell);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("heightmap_slope_classifier_top: mismatch");
      $finish;
    end
  end

  initial begin
    map_width_reg = 7'(hsc_pkg::RST_MAP_WIDTH);
    map_depth_reg = 13'(hsc_pkg::RST_MAP_DEPTH);
    flat_limit = 16'(hsc_pkg::RST_FLAT_THRESHOLD);
    build_limit = 16'(hsc_pkg::RST_BUILD_THRESHOLD);
    foreach (height_line[i, j]) begin
      height_line[i][j] = '0;
      water_line[i][j] = 1'b0;
    end
    restart_map();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_field_extremes();
    test_single_cells();
    test_single_row();
    test_single_column();
    test_crossed_thresholds();
    test_zero_sizes();
    test_random_maps();
    test_widest_map();
    test_deepest_map();

    // Drain, then watch a little longer for stray results.
    wait_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && cell_queue.size() == 0) begin
      $display("heightmap_slope_classifier_top: match");
    end else begin
      $display("heightmap_slope_classifier_top: mismatch");
    end
    $finish;
  end

endmodule
